// ===== src/lact_pkg.sv =====
// ----------------------------------------------------------------------------
// lact_pkg: shared types and constants
// Word widths, opcodes and control bundles of the look-at camera transform.
// ----------------------------------------------------------------------------
package lact_pkg;

  localparam int CoordW = 32;
  localparam int FracB  = 16;
  localparam int MulW   = CoordW + 1;
  localparam int ProdW  = 2 * MulW;
  localparam int AccW   = ProdW + 2;
  localparam int MagW   = 48;
  localparam int RadW   = 60;
  localparam int RootW  = 30;
  localparam int QuoW   = 46;
  localparam int RemW   = 34;
  localparam int CntW   = 6;

  localparam logic [MagW-1:0] FitHi = MagW'(1) << 29;
  localparam logic [MagW-1:0] FitLo = MagW'(1) << 28;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_W2C = 2'd1;
  localparam logic [1:0] OP_C2W = 2'd2;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [1:0] tag;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rd_ctl_t;

endpackage

// ===== src/lact_mac.sv =====
// ----------------------------------------------------------------------------
// lact_mac: shared multiply-accumulate unit
// Registered signed product followed by a grouped accumulator.
// ----------------------------------------------------------------------------
module lact_mac import lact_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_ctl_t               ctl_i,
  input  logic signed [MulW-1:0] a_i,
  input  logic signed [MulW-1:0] b_i,
  output logic                   done_o,
  output logic [1:0]             tag_o,
  output logic signed [AccW-1:0] acc_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  mac_ctl_t                ctl_q;
  logic                    done_q;
  logic [1:0]              tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
      ctl_q  <= '0;
      done_q <= 1'b0;
      tag_q  <= '0;
    end else begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
      ctl_q  <= ctl_i;
      if (ctl_q.vld) begin
        acc_q <= ctl_q.first ? AccW'(prod_q) : acc_q + AccW'(prod_q);
      end
      done_q <= ctl_q.vld & ctl_q.last;
      tag_q  <= ctl_q.tag;
    end
  end

  assign done_o = done_q;
  assign tag_o  = tag_q;
  assign acc_o  = acc_q;

endmodule

// ===== src/lact_rootdiv.sv =====
// ----------------------------------------------------------------------------
// lact_rootdiv: iterative square root and divider
// One remainder datapath, a root or quotient bit per cycle.
// ----------------------------------------------------------------------------
module lact_rootdiv import lact_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rd_ctl_t           ctl_i,
  input  logic [RadW-1:0]   opa_i,
  input  logic [RootW-1:0]  dsr_i,
  output logic              done_o,
  output logic [CoordW-1:0] res_o
);

  logic             busy_q, div_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [RemW-1:0]  rem_q;
  logic [RadW-1:0]  num_q;
  logic [QuoW-1:0]  res_q;
  logic [RootW-1:0] dsr_q;
  logic [RemW-1:0]  rem2, trial;
  logic             ge;

  always_comb begin
    if (div_q) begin
      rem2  = {rem_q[RemW-2:0], num_q[RadW-1]};
      trial = RemW'(dsr_q);
    end else begin
      rem2  = {rem_q[RemW-3:0], num_q[RadW-1:RadW-2]};
      trial = {res_q[RemW-3:0], 2'b01};
    end
    ge = (rem2 >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      num_q  <= '0;
      res_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        div_q  <= ctl_i.is_div;
        cnt_q  <= ctl_i.is_div ? CntW'(QuoW) : CntW'(RootW);
        rem_q  <= '0;
        num_q  <= opa_i;
        res_q  <= '0;
        dsr_q  <= dsr_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem2 - trial : rem2;
        res_q <= {res_q[QuoW-2:0], ge};
        num_q <= div_q ? {num_q[RadW-2:0], 1'b0} : {num_q[RadW-3:0], 2'b00};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q[CoordW-1:0];

endmodule

// ===== src/look_at_camera_transform_top.sv =====
// ----------------------------------------------------------------------------
// look_at_camera_transform_top: look-at camera transform in Q16.16
// Builds a view matrix from target and up, and maps points both ways.
// ----------------------------------------------------------------------------
// One request at a time. A world-to-camera or camera-to-world request
// accepts its inputs, sends twelve products through the one shared
// multiplier, drains the accumulator and loads the result register (once
// any earlier result has been taken) before the next request can be taken.
// A set-view request spends most of its time in the shared root/divide
// unit (two roots and six quotients), plus the power-of-two rescale steps
// of the three rescales; a degenerate vector ends it early. A finished
// result waits in its own register, so the next request is taken while it
// is pending.
// Origin writes take effect at the next set view.
module look_at_camera_transform_top import lact_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [CoordW-1:0] vec_x_i,
  input  logic [CoordW-1:0] vec_y_i,
  input  logic [CoordW-1:0] vec_z_i,
  input  logic [CoordW-1:0] up_x_i,
  input  logic [CoordW-1:0] up_y_i,
  input  logic [CoordW-1:0] up_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] out_x_o,
  output logic [CoordW-1:0] out_y_o,
  output logic [CoordW-1:0] out_z_o,
  output logic              status_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CoordW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_FIT, ST_ISSUE, ST_WAIT, ST_SQRT, ST_DIV, ST_DIVW,
    ST_COMMIT, ST_OUT
  } state_e;

  typedef enum logic [2:0] {K_SQ, K_CR1, K_CR2, K_TR, K_XF} kind_e;
  typedef enum logic [1:0] {P_F, P_U, P_R} pass_e;

  typedef logic signed [CoordW-1:0] word_t;

  state_e state_q;
  kind_e  kind_q;
  pass_e  pass_q;
  logic [1:0] op_q, g_q, t_q, i_q;

  word_t org_q [3];
  word_t vin_q [3];
  word_t upin_q [3];
  logic [MagW-1:0] m_q [3];
  logic            sg_q [3];
  word_t fw_q [3];
  word_t rt_q [3];
  word_t wu_q [3];
  word_t ut_q [3];
  word_t wt_q [3];
  logic [RootW-1:0] s_q;
  word_t ax_q [3][3];
  word_t vt_q [3];
  word_t ot_q [3];
  word_t rx_q [3];
  logic  st_q;
  word_t ox_q [3];
  logic  ostat_q, oval_q;

  mac_ctl_t               mac_ctl;
  logic signed [MulW-1:0] ma, mb;
  logic                   mac_done;
  logic [1:0]             mac_tag;
  logic signed [AccW-1:0] acc;

  rd_ctl_t          rd_ctl;
  logic [RadW-1:0]  rd_opa;
  logic             rd_done;
  logic [CoordW-1:0] rd_res;

  logic [MagW-1:0] top;
  logic            t_last, g_last, grp_done;
  logic [QuoW-1:0] numer;

  function automatic logic signed [MulW-1:0] sx(input word_t v);
    return MulW'(v);
  endfunction

  function automatic logic [1:0] nx1(input logic [1:0] g);
    logic [1:0] r;
    case (g)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nx2(input logic [1:0] g);
    logic [1:0] r;
    case (g)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [AccW-1:0] absv(input logic signed [AccW-1:0] a);
    return a[AccW-1] ? AccW'(-a) : AccW'(a);
  endfunction

  // round half up, shift, saturate
  function automatic word_t wfinish(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] r;
    logic signed [AccW-1:0] sh;
    word_t                  o;
    r  = a + (AccW'(1) <<< (FracB - 1));
    sh = r >>> FracB;
    if (sh > AccW'(signed'({1'b0, {(CoordW-1){1'b1}}})))
      o = {1'b0, {(CoordW-1){1'b1}}};
    else if (sh < -(AccW'(1) <<< (CoordW - 1)))
      o = {1'b1, {(CoordW-1){1'b0}}};
    else
      o = sh[CoordW-1:0];
    return o;
  endfunction

  // round half away from zero, shift
  function automatic word_t rshr(input logic signed [AccW-1:0] a);
    logic [AccW-1:0] m;
    logic [AccW-1:0] r;
    m = absv(a);
    r = (m + (AccW'(1) << (FracB - 1))) >> FracB;
    return a[AccW-1] ? word_t'(-r[CoordW-1:0]) : word_t'(r[CoordW-1:0]);
  endfunction

  function automatic word_t axw(input logic [1:0] g, input logic [1:0] t,
                                input word_t r0 [3], input word_t u0 [3],
                                input word_t f0 [3]);
    word_t v;
    case (g)
      2'd0:    v = r0[t];
      2'd1:    v = u0[t];
      default: v = f0[t];
    endcase
    return v;
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (kind_q)
      K_SQ: begin
        ma = MulW'(m_q[t_q][RootW-1:0]);
        mb = ma;
      end
      K_CR1: begin
        if (t_q == 2'd0) begin
          ma = sx(ut_q[nx1(g_q)]);
          mb = sx(fw_q[nx2(g_q)]);
        end else begin
          ma = sx(ut_q[nx2(g_q)]);
          mb = -sx(fw_q[nx1(g_q)]);
        end
      end
      K_CR2: begin
        if (t_q == 2'd0) begin
          ma = sx(fw_q[nx1(g_q)]);
          mb = sx(rt_q[nx2(g_q)]);
        end else begin
          ma = sx(fw_q[nx2(g_q)]);
          mb = -sx(rt_q[nx1(g_q)]);
        end
      end
      K_TR: begin
        ma = -sx(axw(g_q, t_q, rt_q, wu_q, fw_q));
        mb = sx(org_q[t_q]);
      end
      K_XF: begin
        if (t_q == 2'd3) begin
          ma = (op_q == OP_C2W) ? sx(ot_q[g_q]) : sx(vt_q[g_q]);
          mb = MulW'(1) <<< FracB;
        end else begin
          ma = (op_q == OP_C2W) ? sx(ax_q[t_q][g_q]) : sx(ax_q[g_q][t_q]);
          mb = sx(vin_q[t_q]);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    case (kind_q)
      K_SQ, K_TR: t_last = (t_q == 2'd2);
      K_XF:       t_last = (t_q == 2'd3);
      default:    t_last = (t_q == 2'd1);
    endcase
    g_last   = (kind_q == K_SQ) || (g_q == 2'd2);
    grp_done = mac_done && (mac_tag == ((kind_q == K_SQ) ? 2'd0 : 2'd2));
    mac_ctl.vld   = (state_q == ST_ISSUE);
    mac_ctl.first = (t_q == 2'd0);
    mac_ctl.last  = t_last;
    mac_ctl.tag   = g_q;

    top = m_q[0];
    if (m_q[1] > top) top = m_q[1];
    if (m_q[2] > top) top = m_q[2];

    numer = QuoW'({m_q[i_q][RootW-1:0], {FracB{1'b0}}}) + QuoW'(s_q[RootW-1:1]);
    rd_ctl.is_div = (state_q == ST_DIV);
    rd_ctl.start  = (state_q == ST_DIV) ||
                    (state_q == ST_WAIT && grp_done && kind_q == K_SQ);
    rd_opa = (state_q == ST_DIV) ? {numer, {(RadW-QuoW){1'b0}}} : acc[RadW-1:0];
  end

  lact_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (ma),
    .b_i    (mb),
    .done_o (mac_done),
    .tag_o  (mac_tag),
    .acc_o  (acc)
  );

  lact_rootdiv u_rootdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rd_ctl),
    .opa_i  (rd_opa),
    .dsr_i  (s_q),
    .done_o (rd_done),
    .res_o  (rd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= K_SQ;
      pass_q  <= P_F;
      op_q    <= '0;
      g_q     <= '0;
      t_q     <= '0;
      i_q     <= '0;
      s_q     <= '0;
      st_q    <= 1'b0;
      ostat_q <= 1'b0;
      oval_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        org_q[k]  <= '0;
        vin_q[k]  <= '0;
        upin_q[k] <= '0;
        m_q[k]    <= '0;
        sg_q[k]   <= 1'b0;
        fw_q[k]   <= '0;
        rt_q[k]   <= '0;
        wu_q[k]   <= '0;
        ut_q[k]   <= '0;
        wt_q[k]   <= '0;
        vt_q[k]   <= '0;
        ot_q[k]   <= '0;
        rx_q[k]   <= '0;
        ox_q[k]   <= '0;
        for (int n = 0; n < 3; n++) begin
          ax_q[k][n] <= (k == n) ? word_t'(1) <<< FracB : '0;
        end
      end
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_ORIGIN_Z) begin
        org_q[cfg_idx_i] <= cfg_data_i;
      end
      if (oval_q && out_ready_i && state_q != ST_OUT) begin
        oval_q <= 1'b0;
      end

      // capture finished accumulator groups
      if (mac_done) begin
        case (kind_q)
          K_CR1: begin
            m_q[mac_tag]  <= MagW'(absv(acc));
            sg_q[mac_tag] <= acc[AccW-1];
          end
          K_CR2:   wu_q[mac_tag] <= rshr(acc);
          K_TR:    wt_q[mac_tag] <= wfinish(acc);
          K_XF:    rx_q[mac_tag] <= wfinish(acc);
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q      <= opcode_i;
            vin_q[0]  <= vec_x_i;
            vin_q[1]  <= vec_y_i;
            vin_q[2]  <= vec_z_i;
            upin_q[0] <= up_x_i;
            upin_q[1] <= up_y_i;
            upin_q[2] <= up_z_i;
            st_q      <= 1'b0;
            g_q       <= '0;
            t_q       <= '0;
            for (int k = 0; k < 3; k++) rx_q[k] <= '0;
            case (opcode_i)
              OP_SET: begin
                pass_q  <= P_F;
                state_q <= ST_DIFF;
              end
              OP_W2C, OP_C2W: begin
                kind_q  <= K_XF;
                state_q <= ST_ISSUE;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end

        ST_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            logic signed [CoordW+1:0] d;
            d = (CoordW+2)'(vin_q[k]) - (CoordW+2)'(org_q[k]);
            m_q[k]  <= MagW'(d[CoordW+1] ? -d : d);
            sg_q[k] <= d[CoordW+1];
          end
          state_q <= ST_FIT;
        end

        ST_FIT: begin
          if (top == '0) begin
            st_q    <= 1'b1;
            state_q <= ST_OUT;
          end else if (top > FitHi) begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
          end else if (top < FitLo) begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
          end else begin
            g_q <= '0;
            t_q <= '0;
            if (pass_q == P_U) begin
              for (int k = 0; k < 3; k++) begin
                ut_q[k] <= sg_q[k] ? -word_t'(m_q[k][CoordW-1:0])
                                   : word_t'(m_q[k][CoordW-1:0]);
              end
              kind_q <= K_CR1;
            end else begin
              kind_q <= K_SQ;
            end
            state_q <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          if (t_last) begin
            t_q <= '0;
            if (g_last) state_q <= ST_WAIT;
            else        g_q <= g_q + 2'd1;
          end else begin
            t_q <= t_q + 2'd1;
          end
        end

        ST_WAIT: begin
          if (grp_done) begin
            g_q <= '0;
            t_q <= '0;
            case (kind_q)
              K_SQ:  state_q <= ST_SQRT;
              K_CR1: begin
                pass_q  <= P_R;
                state_q <= ST_FIT;
              end
              K_CR2: begin
                kind_q  <= K_TR;
                state_q <= ST_ISSUE;
              end
              K_TR:    state_q <= ST_COMMIT;
              default: state_q <= ST_OUT;
            endcase
          end
        end

        ST_SQRT: begin
          if (rd_done) begin
            s_q     <= rd_res[RootW-1:0];
            i_q     <= '0;
            state_q <= ST_DIV;
          end
        end

        ST_DIV: state_q <= ST_DIVW;

        ST_DIVW: begin
          if (rd_done) begin
            if (pass_q == P_F) begin
              fw_q[i_q] <= sg_q[i_q] ? -word_t'(rd_res) : word_t'(rd_res);
            end else begin
              rt_q[i_q] <= sg_q[i_q] ? -word_t'(rd_res) : word_t'(rd_res);
            end
            if (i_q == 2'd2) begin
              if (pass_q == P_F) begin
                for (int k = 0; k < 3; k++) begin
                  m_q[k]  <= MagW'(upin_q[k][CoordW-1] ? -(CoordW+1)'(upin_q[k])
                                                      : (CoordW+1)'(upin_q[k]));
                  sg_q[k] <= upin_q[k][CoordW-1];
                end
                pass_q  <= P_U;
                state_q <= ST_FIT;
              end else begin
                g_q     <= '0;
                t_q     <= '0;
                kind_q  <= K_CR2;
                state_q <= ST_ISSUE;
              end
            end else begin
              i_q     <= i_q + 2'd1;
              state_q <= ST_DIV;
            end
          end
        end

        ST_COMMIT: begin
          for (int k = 0; k < 3; k++) begin
            ax_q[0][k] <= rt_q[k];
            ax_q[1][k] <= wu_q[k];
            ax_q[2][k] <= fw_q[k];
            vt_q[k]    <= wt_q[k];
            ot_q[k]    <= org_q[k];
          end
          state_q <= ST_OUT;
        end

        ST_OUT: begin
          if (!oval_q || out_ready_i) begin
            for (int k = 0; k < 3; k++) ox_q[k] <= rx_q[k];
            ostat_q <= st_q;
            oval_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;
  assign out_x_o     = ox_q[0];
  assign out_y_o     = ox_q[1];
  assign out_z_o     = ox_q[2];
  assign status_o    = ostat_q;

endmodule
